### src/ili_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ili_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned TDATA_W  = 48;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Memory write source
  typedef enum logic [1:0] {
    WSEL_APPEND,
    WSEL_POS,
    WSEL_SHIFT
  } wsel_e;

  // Memory read address source
  typedef enum logic [1:0] {
    RSEL_POS,
    RSEL_UP,
    RSEL_DOWN
  } rsel_e;

  // Fill count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Shift index update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_CNT,
    IDX_LOAD_POS,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    mem_we;
    wsel_e   wsel;
    logic    mem_re;
    rsel_e   rsel;
    logic    cap_read;
    cnt_op_e cnt_op;
    idx_op_e idx_op;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             ok;
    logic             ins_more;
    logic             del_more;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/indexed_list_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none

// Indexed list with insert and delete.
// Slave stream: one command word per transfer (clear, append, read, insert,
// update, delete). Master stream: one result word per command with status,
// read data and the fill count after the command.
// Flow: each command is latched, checked in a dispatch state and finished in a
// done state; a read adds a state that waits for the registered read data.
// Insert and delete move the later entries one at a time through the list
// memory (a registered read, then a write) before reaching the done state.
// One command is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// Reset clears the fill count and the output valid flag; list storage is not
// cleared and is only read below the fill count.
// When the receiver stalls, the result word is held, the next command runs
// and then waits in its final state until the output register frees up.
module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] cmd, [8:3] position, [40:9] value, [47:41] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [33:2] read_value, [40:34] count, [47:41] zero
  output logic      [47:0] m_axis_tdata
);

  ili_pkg::dp_cmd_t  dp_cmd;
  ili_pkg::dp_stat_t dp_stat;

  ili_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (dp_stat),
    .cmd_o         (dp_cmd)
  );

  ili_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_data_i     (s_axis_tdata),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### src/ili_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ili_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/ili_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ili_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire ili_pkg::dp_stat_t stat_i,
  output ili_pkg::dp_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_READ_WAIT = 3'd2;
  localparam logic [2:0] S_SHIFT_RD  = 3'd3;
  localparam logic [2:0] S_SHIFT_WR  = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0] state_q, state_d;
  logic       is_insert;

  assign s_axis_tready = (state_q == S_IDLE);
  assign is_insert     = (stat_i.cmd == ili_pkg::CMD_INSERT);

  // Sequence one command through the datapath
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.wsel    = ili_pkg::WSEL_POS;
    cmd_o.rsel    = ili_pkg::RSEL_POS;
    cmd_o.cnt_op  = ili_pkg::CNT_HOLD;
    cmd_o.idx_op  = ili_pkg::IDX_HOLD;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_DONE;
        if (stat_i.ok) begin
          case (stat_i.cmd)
            ili_pkg::CMD_CLEAR: begin
              cmd_o.cnt_op = ili_pkg::CNT_CLEAR;
            end
            ili_pkg::CMD_APPEND: begin
              cmd_o.mem_we = 1'b1;
              cmd_o.wsel   = ili_pkg::WSEL_APPEND;
              cmd_o.cnt_op = ili_pkg::CNT_INC;
            end
            ili_pkg::CMD_READ: begin
              cmd_o.mem_re = 1'b1;
              cmd_o.rsel   = ili_pkg::RSEL_POS;
              state_d      = S_READ_WAIT;
            end
            ili_pkg::CMD_INSERT: begin
              cmd_o.idx_op = ili_pkg::IDX_LOAD_CNT;
              state_d      = S_SHIFT_RD;
            end
            ili_pkg::CMD_UPDATE: begin
              cmd_o.mem_we = 1'b1;
              cmd_o.wsel   = ili_pkg::WSEL_POS;
            end
            ili_pkg::CMD_DELETE: begin
              cmd_o.idx_op = ili_pkg::IDX_LOAD_POS;
              state_d      = S_SHIFT_RD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ_WAIT: begin
        cmd_o.cap_read = 1'b1;
        state_d        = S_DONE;
      end
      S_SHIFT_RD: begin
        // Fetch the neighbor, or finish the shift
        if (is_insert) begin
          if (stat_i.ins_more) begin
            cmd_o.mem_re = 1'b1;
            cmd_o.rsel   = ili_pkg::RSEL_DOWN;
            state_d      = S_SHIFT_WR;
          end else begin
            cmd_o.mem_we = 1'b1;
            cmd_o.wsel   = ili_pkg::WSEL_POS;
            cmd_o.cnt_op = ili_pkg::CNT_INC;
            state_d      = S_DONE;
          end
        end else begin
          if (stat_i.del_more) begin
            cmd_o.mem_re = 1'b1;
            cmd_o.rsel   = ili_pkg::RSEL_UP;
            state_d      = S_SHIFT_WR;
          end else begin
            cmd_o.cnt_op = ili_pkg::CNT_DEC;
            state_d      = S_DONE;
          end
        end
      end
      S_SHIFT_WR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = ili_pkg::WSEL_SHIFT;
        cmd_o.idx_op = is_insert ? ili_pkg::IDX_DEC : ili_pkg::IDX_INC;
        state_d      = S_SHIFT_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shifting only happens for insert or delete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD || state_q == S_SHIFT_WR) |->
      (stat_i.cmd == ili_pkg::CMD_INSERT || stat_i.cmd == ili_pkg::CMD_DELETE))
    else $error("shift state for a command that does not shift");

  // A new word is taken only after the previous result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> !cmd_o.latch)
    else $error("two words accepted back to back");

  // Results are loaded only from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE))
    else $error("result loaded without returning to idle");

endmodule

`default_nettype wire

### src/ili_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ili_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [ili_pkg::TDATA_W-1:0]    in_data_i,
  input  wire ili_pkg::dp_cmd_t               cmd_i,
  output ili_pkg::dp_stat_t                   stat_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [ili_pkg::TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > ili_pkg::POS_W) ? CNT_W + 1 : ili_pkg::POS_W + 1;
  localparam int unsigned OUT_W  = (CNT_W > ili_pkg::COUNT_W) ? CNT_W : ili_pkg::COUNT_W;
  localparam int unsigned OUT_BITS = ili_pkg::STATUS_W + ili_pkg::DATA_W + ili_pkg::COUNT_W;

  // Input fields
  logic [ili_pkg::CMD_W-1:0]  in_cmd;
  logic [ili_pkg::POS_W-1:0]  in_pos;
  logic [ili_pkg::DATA_W-1:0] in_val;

  assign in_cmd = in_data_i[ili_pkg::CMD_W-1:0];
  assign in_pos = in_data_i[ili_pkg::CMD_W +: ili_pkg::POS_W];
  assign in_val = in_data_i[ili_pkg::CMD_W + ili_pkg::POS_W +: ili_pkg::DATA_W];

  // Held command state
  logic [ili_pkg::CMD_W-1:0]    cmd_q;
  logic [ili_pkg::POS_W-1:0]    pos_q;
  logic [ili_pkg::DATA_W-1:0]   val_q;
  logic [ili_pkg::STATUS_W-1:0] status_q, status_d;
  logic [ili_pkg::DATA_W-1:0]   rd_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [ADDR_W-1:0]            idx_q;

  // Output register
  logic                         out_valid_q;
  logic [ili_pkg::STATUS_W-1:0] out_status_q;
  logic [ili_pkg::DATA_W-1:0]   out_rd_q;
  logic [ili_pkg::COUNT_W-1:0]  out_cnt_q;

  // Wide compare operands
  logic [CMP_W-1:0]  pos_in_x, pos_q_x, cnt_x, idx_x;
  logic [ADDR_W-1:0] pos_a, cnt_a;
  logic [OUT_W-1:0]  cnt_o;
  logic              full, pos_ge, pos_gt;

  assign pos_in_x = CMP_W'(in_pos);
  assign pos_q_x  = CMP_W'(pos_q);
  assign cnt_x    = CMP_W'(cnt_q);
  assign idx_x    = CMP_W'(idx_q);
  assign pos_a    = pos_q_x[ADDR_W-1:0];
  assign cnt_a    = cnt_q[ADDR_W-1:0];
  assign cnt_o    = OUT_W'(cnt_q);
  assign full     = (cnt_x == CMP_W'(CAPACITY));
  assign pos_ge   = (pos_in_x >= cnt_x);
  assign pos_gt   = (pos_in_x > cnt_x);

  // Check the incoming command against the fill count
  always_comb begin
    status_d = ili_pkg::ST_OK;
    case (in_cmd)
      ili_pkg::CMD_APPEND: begin
        if (full) status_d = ili_pkg::ST_FULL;
      end
      ili_pkg::CMD_READ, ili_pkg::CMD_UPDATE, ili_pkg::CMD_DELETE: begin
        if (pos_ge) status_d = ili_pkg::ST_RANGE;
      end
      ili_pkg::CMD_INSERT: begin
        if (pos_gt) status_d = ili_pkg::ST_RANGE;
        else if (full) status_d = ili_pkg::ST_FULL;
      end
      default: begin
        status_d = ili_pkg::ST_OK;
      end
    endcase
  end

  // Memory port selection
  logic [ADDR_W-1:0]         waddr, raddr;
  logic [ili_pkg::DATA_W-1:0] wdata, rdata;

  always_comb begin
    case (cmd_i.wsel)
      ili_pkg::WSEL_APPEND: begin
        waddr = cnt_a;
        wdata = val_q;
      end
      ili_pkg::WSEL_SHIFT: begin
        waddr = idx_q;
        wdata = rdata;
      end
      default: begin
        waddr = pos_a;
        wdata = val_q;
      end
    endcase
    case (cmd_i.rsel)
      ili_pkg::RSEL_UP:   raddr = idx_q + ADDR_W'(1);
      ili_pkg::RSEL_DOWN: raddr = idx_q - ADDR_W'(1);
      default:            raddr = pos_a;
    endcase
  end

  ili_ram #(
    .WIDTH (ili_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Latch the command, capture read data, step the shift index and load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q    <= in_cmd;
      pos_q    <= in_pos;
      val_q    <= in_val;
      status_q <= status_d;
      rd_q     <= '0;
    end else if (cmd_i.cap_read) begin
      rd_q <= rdata;
    end
    case (cmd_i.idx_op)
      ili_pkg::IDX_LOAD_CNT: idx_q <= cnt_a;
      ili_pkg::IDX_LOAD_POS: idx_q <= pos_a;
      ili_pkg::IDX_INC:      idx_q <= idx_q + ADDR_W'(1);
      ili_pkg::IDX_DEC:      idx_q <= idx_q - ADDR_W'(1);
      default:               idx_q <= idx_q;
    endcase
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_rd_q     <= rd_q;
      out_cnt_q    <= cnt_o[ili_pkg::COUNT_W-1:0];
    end
  end

  // Update the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (cmd_i.cnt_op)
        ili_pkg::CNT_CLEAR: cnt_q <= '0;
        ili_pkg::CNT_INC:   cnt_q <= cnt_q + CNT_W'(1);
        ili_pkg::CNT_DEC:   cnt_q <= cnt_q - CNT_W'(1);
        default:            cnt_q <= cnt_q;
      endcase
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ili_pkg::TDATA_W - OUT_BITS){1'b0}},
                          out_cnt_q, out_rd_q, out_status_q};

  assign stat_o.cmd      = cmd_q;
  assign stat_o.ok       = (status_q == ili_pkg::ST_OK);
  assign stat_o.ins_more = (idx_q > pos_a);
  assign stat_o.del_more = ((idx_x + CMP_W'(1)) < cnt_x);
  assign stat_o.out_free = !out_valid_q || m_axis_tready;

  // Fill count stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= CMP_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // Growth only below capacity, shrink only above zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt_op == ili_pkg::CNT_INC) |-> !full)
    else $error("count raised on a full list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt_op == ili_pkg::CNT_DEC) |-> (cnt_q != '0))
    else $error("count lowered on an empty list");

  // A pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten");

endmodule

`default_nettype wire
